@@ sv/crbc_pkg.sv @@
// crbc_pkg: shared types and constants for the Catmull-Rom to Bezier control point block.
// Used by crbc_front, crbc_queue, crbc_back and catmull_rom_bezier_controls; no dependencies.
`default_nettype none

package crbc_pkg;

	localparam int COORD_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// point slots of a queued job
	localparam logic [1:0] PT_Q0  = 2'd0;
	localparam logic [1:0] PT_Q1  = 2'd1;
	localparam logic [1:0] PT_Q2  = 2'd2;
	localparam logic [1:0] PT_NEW = 2'd3;

	// axis of a point slot
	localparam logic AX_X = 1'b0;
	localparam logic AX_Y = 1'b1;

	// result kinds as they leave on tuser
	typedef enum logic [2:0] {
		KIND_START = 3'd0,
		KIND_CTRL1 = 3'd1,
		KIND_CTRL2 = 3'd2,
		KIND_END   = 3'd3,
		KIND_PLAIN = 3'd4
	} kind_t;

	// back-end emission sequence
	typedef enum logic [3:0] {
		PH_START,
		PH_CTRL1_A,
		PH_CTRL2_A,
		PH_END_A,
		PH_CTRL1_B,
		PH_CTRL2_B,
		PH_END_B,
		PH_PLAIN_A,
		PH_PLAIN_B
	} phase_t;

	// job classification from the front end
	typedef struct packed {
		logic plain;     // two plain vertices: Q2 then NEW
		logic has_start; // emit start point Q1 before first segment
		logic last;      // curve ends here: second segment, end-of-curve flag
	} job_ctl_t;

	localparam int CTL_BITS = $bits(job_ctl_t);

endpackage

`default_nettype wire

@@ sv/crbc_front.sv @@
// crbc_front: vertex window and job classification.
// Depends on crbc_pkg; feeds jobs into crbc_queue.
`default_nettype none

module crbc_front #(
	parameter int COORD_BITS = crbc_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_fire,
	input  logic [COORD_BITS-1:0]               in_x,
	input  logic [COORD_BITS-1:0]               in_y,
	input  logic                                in_last,
	output logic                                push,
	output crbc_pkg::job_ctl_t                  job_ctl,
	output logic [3:0][1:0][COORD_BITS-1:0]     job_pts
);

	logic [1:0]                       count_q; // vertices held, saturates at 3
	logic [2:0][1:0][COORD_BITS-1:0]  win_q;   // oldest first

	always_comb begin
		push              = in_fire && ((count_q == 2'd2) || (count_q == 2'd3) ||
			((count_q == 2'd1) && in_last));
		job_ctl.plain     = (count_q == 2'd1);
		job_ctl.has_start = (count_q == 2'd2);
		job_ctl.last      = in_last;
		job_pts[crbc_pkg::PT_NEW][crbc_pkg::AX_X] = in_x;
		job_pts[crbc_pkg::PT_NEW][crbc_pkg::AX_Y] = in_y;
		unique case (count_q)
			2'd1, 2'd2: begin
				// start of curve: missing neighbour is the first vertex itself
				job_pts[crbc_pkg::PT_Q0] = win_q[0];
				job_pts[crbc_pkg::PT_Q1] = win_q[0];
				job_pts[crbc_pkg::PT_Q2] = (count_q == 2'd1) ? win_q[0] : win_q[1];
			end
			default: begin
				job_pts[crbc_pkg::PT_Q0] = win_q[0];
				job_pts[crbc_pkg::PT_Q1] = win_q[1];
				job_pts[crbc_pkg::PT_Q2] = win_q[2];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (in_fire) begin
			if (in_last) begin
				count_q <= 2'd0;
			end else if (count_q != 2'd3) begin
				count_q <= count_q + 2'd1;
			end
		end
	end

	// window is payload, no reset
	always_ff @(posedge clk) begin
		if (in_fire && !in_last) begin
			case (count_q)
				2'd0: win_q[0] <= {in_y, in_x};
				2'd1: win_q[1] <= {in_y, in_x};
				2'd2: win_q[2] <= {in_y, in_x};
				default: begin
					win_q[0] <= win_q[1];
					win_q[1] <= win_q[2];
					win_q[2] <= {in_y, in_x};
				end
			endcase
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_last |=> count_q == 2'd0)
		else $error("window count not cleared after last vertex");

endmodule

`default_nettype wire

@@ sv/crbc_queue.sv @@
// crbc_queue: short job queue between front and back end.
// Depends on crbc_pkg for the default depth.
`default_nettype none

module crbc_queue #(
	parameter int DATA_BITS = 8,
	parameter int DEPTH     = crbc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DATA_BITS-1:0] push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output logic [DATA_BITS-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_DEPTH = CW'(DEPTH);

	logic [DATA_BITS-1:0] mem_q [DEPTH];
	logic [PW-1:0]        wr_ptr_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [CW-1:0]        count_q;

	assign full      = (count_q == CNT_DEPTH);
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("job popped from empty queue");

endmodule

`default_nettype wire

@@ sv/crbc_back.sv @@
// crbc_back: emission sequencer, divide-by-6 datapath, clamp and output register.
// Depends on crbc_pkg; takes jobs from crbc_queue.
`default_nettype none

module crbc_back #(
	parameter int COORD_BITS = crbc_pkg::COORD_BITS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              q_valid,
	input  logic [crbc_pkg::CTL_BITS+8*COORD_BITS-1:0]        q_data,
	output logic                                              pop,
	output logic                                              out_valid,
	input  logic                                              out_ready,
	output logic [COORD_BITS+1:0]                             out_x,
	output logic [COORD_BITS-1:0]                             out_y,
	output crbc_pkg::kind_t                                   out_kind,
	output logic                                              out_run_last,
	output logic                                              out_curve_end
);

	localparam int CB       = COORD_BITS;
	localparam int PTS_BITS = 8 * CB;
	localparam int QB       = CB - 2;     // |diff|/6 width
	localparam int DIV_SHIFT = CB + 1;    // (CB-1)-bit dividend, exact reciprocal of 3
	localparam logic [63:0] RECIP3_FULL = ((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3;
	localparam logic [CB-1:0] RECIP3 = RECIP3_FULL[CB-1:0];

	// ---------------- sequencer ----------------
	crbc_pkg::job_ctl_t               new_ctl;
	logic [3:0][1:0][CB-1:0]          new_pts;
	crbc_pkg::job_ctl_t               cur_ctl_q;
	logic [3:0][1:0][CB-1:0]          cur_pts_q;
	logic                             busy_q;
	crbc_pkg::phase_t                 phase_q;
	crbc_pkg::phase_t                 next_phase;
	crbc_pkg::phase_t                 first_phase;
	logic                             adv;
	logic                             issue;
	logic                             at_final;

	assign new_ctl = crbc_pkg::job_ctl_t'(q_data[crbc_pkg::CTL_BITS+PTS_BITS-1:PTS_BITS]);
	assign new_pts = q_data[PTS_BITS-1:0];

	assign adv   = !out_valid || out_ready;
	assign issue = busy_q && adv;
	assign pop   = q_valid && (!busy_q || (issue && at_final));

	assign first_phase = new_ctl.plain ? crbc_pkg::PH_PLAIN_A :
		(new_ctl.has_start ? crbc_pkg::PH_START : crbc_pkg::PH_CTRL1_A);

	always_comb begin
		unique case (phase_q)
			crbc_pkg::PH_START:   next_phase = crbc_pkg::PH_CTRL1_A;
			crbc_pkg::PH_CTRL1_A: next_phase = crbc_pkg::PH_CTRL2_A;
			crbc_pkg::PH_CTRL2_A: next_phase = crbc_pkg::PH_END_A;
			crbc_pkg::PH_END_A:   next_phase = crbc_pkg::PH_CTRL1_B;
			crbc_pkg::PH_CTRL1_B: next_phase = crbc_pkg::PH_CTRL2_B;
			crbc_pkg::PH_CTRL2_B: next_phase = crbc_pkg::PH_END_B;
			crbc_pkg::PH_PLAIN_A: next_phase = crbc_pkg::PH_PLAIN_B;
			default:              next_phase = crbc_pkg::PH_START;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= crbc_pkg::PH_START;
		end else if (pop) begin
			busy_q  <= 1'b1;
			phase_q <= first_phase;
		end else if (issue) begin
			if (at_final) begin
				busy_q <= 1'b0;
			end else begin
				phase_q <= next_phase;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_ctl_q <= new_ctl;
			cur_pts_q <= new_pts;
		end
	end

	// per-phase operand selection
	logic             seg_b;
	logic [1:0][CB-1:0] p0, p1, p2, p3;
	logic [CB-1:0]    base_x, base_y, lo_y, hi_y;
	logic [CB:0]      diff_x, diff_y;
	logic             clamp_en;
	crbc_pkg::kind_t  kind;

	always_comb begin
		seg_b = (phase_q == crbc_pkg::PH_CTRL1_B) || (phase_q == crbc_pkg::PH_CTRL2_B) ||
			(phase_q == crbc_pkg::PH_END_B);
		p0 = seg_b ? cur_pts_q[crbc_pkg::PT_Q1] : cur_pts_q[crbc_pkg::PT_Q0];
		p1 = seg_b ? cur_pts_q[crbc_pkg::PT_Q2] : cur_pts_q[crbc_pkg::PT_Q1];
		p2 = seg_b ? cur_pts_q[crbc_pkg::PT_NEW] : cur_pts_q[crbc_pkg::PT_Q2];
		p3 = cur_pts_q[crbc_pkg::PT_NEW];
		if ($signed(p1[crbc_pkg::AX_Y]) < $signed(p2[crbc_pkg::AX_Y])) begin
			lo_y = p1[crbc_pkg::AX_Y];
			hi_y = p2[crbc_pkg::AX_Y];
		end else begin
			lo_y = p2[crbc_pkg::AX_Y];
			hi_y = p1[crbc_pkg::AX_Y];
		end
		at_final = (phase_q == crbc_pkg::PH_END_B) || (phase_q == crbc_pkg::PH_PLAIN_B) ||
			((phase_q == crbc_pkg::PH_END_A) && !cur_ctl_q.last);
		base_x   = p2[crbc_pkg::AX_X];
		base_y   = p2[crbc_pkg::AX_Y];
		diff_x   = '0;
		diff_y   = '0;
		clamp_en = 1'b0;
		kind     = crbc_pkg::KIND_END;
		unique case (phase_q)
			crbc_pkg::PH_START: begin
				base_x = cur_pts_q[crbc_pkg::PT_Q1][crbc_pkg::AX_X];
				base_y = cur_pts_q[crbc_pkg::PT_Q1][crbc_pkg::AX_Y];
				kind   = crbc_pkg::KIND_START;
			end
			crbc_pkg::PH_CTRL1_A, crbc_pkg::PH_CTRL1_B: begin
				// p1 + (p2 - p0)/6
				base_x   = p1[crbc_pkg::AX_X];
				base_y   = p1[crbc_pkg::AX_Y];
				diff_x   = {p2[crbc_pkg::AX_X][CB-1], p2[crbc_pkg::AX_X]} -
					{p0[crbc_pkg::AX_X][CB-1], p0[crbc_pkg::AX_X]};
				diff_y   = {p2[crbc_pkg::AX_Y][CB-1], p2[crbc_pkg::AX_Y]} -
					{p0[crbc_pkg::AX_Y][CB-1], p0[crbc_pkg::AX_Y]};
				clamp_en = 1'b1;
				kind     = crbc_pkg::KIND_CTRL1;
			end
			crbc_pkg::PH_CTRL2_A, crbc_pkg::PH_CTRL2_B: begin
				// p2 - (p3 - p1)/6 == p2 + (p1 - p3)/6 under truncation toward zero
				diff_x   = {p1[crbc_pkg::AX_X][CB-1], p1[crbc_pkg::AX_X]} -
					{p3[crbc_pkg::AX_X][CB-1], p3[crbc_pkg::AX_X]};
				diff_y   = {p1[crbc_pkg::AX_Y][CB-1], p1[crbc_pkg::AX_Y]} -
					{p3[crbc_pkg::AX_Y][CB-1], p3[crbc_pkg::AX_Y]};
				clamp_en = 1'b1;
				kind     = crbc_pkg::KIND_CTRL2;
			end
			crbc_pkg::PH_PLAIN_A: begin
				base_x = cur_pts_q[crbc_pkg::PT_Q2][crbc_pkg::AX_X];
				base_y = cur_pts_q[crbc_pkg::PT_Q2][crbc_pkg::AX_Y];
				kind   = crbc_pkg::KIND_PLAIN;
			end
			crbc_pkg::PH_PLAIN_B: begin
				base_x = cur_pts_q[crbc_pkg::PT_NEW][crbc_pkg::AX_X];
				base_y = cur_pts_q[crbc_pkg::PT_NEW][crbc_pkg::AX_Y];
				kind   = crbc_pkg::KIND_PLAIN;
			end
			default: begin
				kind = crbc_pkg::KIND_END;
			end
		endcase
	end

	// ---------------- stage 1: operands ----------------
	logic            valid_s1;
	logic [CB-1:0]   base_x_s1, base_y_s1, lo_s1, hi_s1;
	logic [CB:0]     diff_x_s1, diff_y_s1;
	logic            clamp_s1, run_last_s1, curve_end_s1;
	crbc_pkg::kind_t kind_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			base_x_s1    <= base_x;
			base_y_s1    <= base_y;
			lo_s1        <= lo_y;
			hi_s1        <= hi_y;
			diff_x_s1    <= diff_x;
			diff_y_s1    <= diff_y;
			clamp_s1     <= clamp_en;
			kind_s1      <= kind;
			run_last_s1  <= at_final;
			curve_end_s1 <= at_final && cur_ctl_q.last;
		end
	end

	// ---------------- stage 2: |diff|/6 by reciprocal multiply ----------------
	// |d|/6 = (|d|>>1)/3; 3 divides exactly via ceil(2^S/3) for a (CB-1)-bit dividend
	logic [CB:0]       mag_x, mag_y;
	logic [2*CB-2:0]   prod_x, prod_y;

	assign mag_x  = diff_x_s1[CB] ? -diff_x_s1 : diff_x_s1;
	assign mag_y  = diff_y_s1[CB] ? -diff_y_s1 : diff_y_s1;
	assign prod_x = (2*CB-1)'(mag_x[CB-1:1]) * (2*CB-1)'(RECIP3);
	assign prod_y = (2*CB-1)'(mag_y[CB-1:1]) * (2*CB-1)'(RECIP3);

	logic            valid_s2;
	logic [CB-1:0]   base_x_s2, base_y_s2, lo_s2, hi_s2;
	logic [QB-1:0]   quo_x_s2, quo_y_s2;
	logic            neg_x_s2, neg_y_s2;
	logic            clamp_s2, run_last_s2, curve_end_s2;
	crbc_pkg::kind_t kind_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			base_x_s2    <= base_x_s1;
			base_y_s2    <= base_y_s1;
			lo_s2        <= lo_s1;
			hi_s2        <= hi_s1;
			quo_x_s2     <= prod_x[2*CB-2:DIV_SHIFT];
			quo_y_s2     <= prod_y[2*CB-2:DIV_SHIFT];
			neg_x_s2     <= diff_x_s1[CB];
			neg_y_s2     <= diff_y_s1[CB];
			clamp_s2     <= clamp_s1;
			kind_s2      <= kind_s1;
			run_last_s2  <= run_last_s1;
			curve_end_s2 <= curve_end_s1;
		end
	end

	// ---------------- output stage: add, clamp ----------------
	logic signed [CB+1:0] off_x, sum_x;
	logic signed [CB:0]   off_y, sum_y, lo_ext, hi_ext;
	logic [CB-1:0]        res_y;

	always_comb begin
		off_x  = neg_x_s2 ? -$signed((CB+2)'(quo_x_s2)) : $signed((CB+2)'(quo_x_s2));
		off_y  = neg_y_s2 ? -$signed((CB+1)'(quo_y_s2)) : $signed((CB+1)'(quo_y_s2));
		sum_x  = $signed({{2{base_x_s2[CB-1]}}, base_x_s2}) + off_x;
		sum_y  = $signed({base_y_s2[CB-1], base_y_s2}) + off_y;
		lo_ext = $signed({lo_s2[CB-1], lo_s2});
		hi_ext = $signed({hi_s2[CB-1], hi_s2});
		if (clamp_s2 && (sum_y < lo_ext)) begin
			res_y = lo_s2;
		end else if (clamp_s2 && (sum_y > hi_ext)) begin
			res_y = hi_s2;
		end else begin
			res_y = sum_y[CB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x         <= sum_x;
			out_y         <= res_y;
			out_kind      <= kind_s2;
			out_run_last  <= run_last_s2;
			out_curve_end <= curve_end_s2;
		end
	end

	a_curve_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_curve_end |-> out_run_last)
		else $error("end of curve without end of run");

	a_idle_issues_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && adv |=> !valid_s1)
		else $error("result issued with no job loaded");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s1) && $stable(valid_s2))
		else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

@@ sv/catmull_rom_bezier_controls.sv @@
// catmull_rom_bezier_controls: top level; Catmull-Rom polyline to cubic Bezier point stream.
// Depends on crbc_pkg, crbc_front, crbc_queue, crbc_back.
//
//  Channel   | Dir | Handshake            | Content
//  ----------+-----+----------------------+------------------------------------------
//  s_axis    | in  | s_tvalid / s_tready  | one polyline vertex, s_tlast on the final one
//  m_axis    | out | m_tvalid / m_tready  | one Bezier point, m_tlast ends a vertex's run
//
// Flow: a vertex occupies the back end for one cycle per result it causes (0, 2, 3,
//   4, 6 or 7) while m_tready does not hold a result; the single result path sets the pace.
//   The first result of a job passes the queue, the sequencer's job register, the operand
//   stage, the reciprocal multiply and the add/clamp output register, in that order.
// Stalls: the front takes a vertex whenever the job queue has room, independent of
//   the output; the back pipeline freezes as a whole while m_tready holds a result.
// Reset: arst_n clears the vertex count, queue pointers and all valid flags.
`default_nettype none

module catmull_rom_bezier_controls #(
	parameter int COORD_BITS  = crbc_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = crbc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// slave side
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// tdata: point_x [COORD_BITS-1:0], point_y [2*COORD_BITS-1:COORD_BITS], zero pad
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
	input  logic                                   s_tlast,   // last_point
	// master side
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// tdata: out_x [COORD_BITS+1:0], out_y [2*COORD_BITS+1:COORD_BITS+2], zero pad
	output logic [((2*COORD_BITS+2+7)/8)*8-1:0]    m_tdata,
	// tuser: point_kind [2:0], end_of_curve [3]
	output logic [3:0]                             m_tuser,
	output logic                                   m_tlast    // last_in_run
);

	localparam int CB        = COORD_BITS;
	localparam int OUT_BITS  = ((2*CB+2+7)/8)*8;
	localparam int JOB_BITS  = crbc_pkg::CTL_BITS + 8*CB;

	logic                         in_fire;
	logic                         q_full;
	logic                         q_push;
	logic                         q_pop;
	logic                         q_not_empty;
	logic [JOB_BITS-1:0]          q_pop_data;
	crbc_pkg::job_ctl_t           job_ctl;
	logic [3:0][1:0][CB-1:0]      job_pts;
	logic [CB+1:0]                res_x;
	logic [CB-1:0]                res_y;
	crbc_pkg::kind_t              res_kind;
	logic                         res_curve_end;

	// front runs whenever the queue has a free slot
	assign s_tready = !q_full;
	assign in_fire  = s_tvalid && s_tready;

	crbc_front #(
		.COORD_BITS (CB)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.in_x    (s_tdata[CB-1:0]),
		.in_y    (s_tdata[2*CB-1:CB]),
		.in_last (s_tlast),
		.push    (q_push),
		.job_ctl (job_ctl),
		.job_pts (job_pts)
	);

	crbc_queue #(
		.DATA_BITS (JOB_BITS),
		.DEPTH     (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({job_ctl, job_pts}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_pop_data)
	);

	crbc_back #(
		.COORD_BITS (CB)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_not_empty),
		.q_data        (q_pop_data),
		.pop           (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_x         (res_x),
		.out_y         (res_y),
		.out_kind      (res_kind),
		.out_run_last  (m_tlast),
		.out_curve_end (res_curve_end)
	);

	// pack result fields, lowest first, zero-filled to whole bytes
	assign m_tdata = OUT_BITS'({res_y, res_x});
	assign m_tuser = {res_curve_end, res_kind};

endmodule

`default_nettype wire

@@ dv/catmull_rom_bezier_controls_tb.sv @@
// catmull_rom_bezier_controls_tb: self-checking bench for the Catmull-Rom to Bezier block.
// Depends on crbc_pkg (kind_t, COORD_BITS_DEF) and catmull_rom_bezier_controls.
// Vertex curves go in over s_axis; a built-in curve predictor checks every m_axis transfer.

module catmull_rom_bezier_controls_tb;

	localparam int CW      = crbc_pkg::COORD_BITS_DEF;
	localparam int SD_W    = ((2*CW+7)/8)*8;
	localparam int MD_W    = ((2*CW+2+7)/8)*8;
	localparam int N_RAND  = 160;
	localparam int IDLE_PC = 6;   // idle cycles per hundred, either side
	localparam int HOLD_AT = 40;  // results seen before the long receiver hold-off
	localparam int HOLD_CY = 80;  // length of that hold-off, in cycles

	// one polyline vertex waiting to be sent
	typedef struct {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic          last;
	} vertex_t;

	// one Bezier point as it should leave the block
	typedef struct {
		logic signed [CW+1:0] x;
		logic signed [CW-1:0] y;
		crbc_pkg::kind_t      kind;
		logic                 run_end;
		logic                 curve_end;
	} bez_pt_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [SD_W-1:0]   s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [MD_W-1:0]   m_tdata;
	logic [3:0]        m_tuser;
	logic              m_tlast;

	vertex_t           vertex_queue[$];
	bez_pt_t           bez_expect[$];

	// predictor state: last three vertices, oldest first, and how many are held
	int                win_x[3];
	int                win_y[3];
	int                pts_held;

	int                err_count = 0;
	int                n_vertices = 0;
	int                n_results = 0;
	int                hold_left = 0;
	logic              hold_done = 1'b0;
	logic              calm;

	catmull_rom_bezier_controls u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// stretch of the run where neither side idles
	assign calm = (n_vertices >= 90) && (n_vertices < 140);

	// ---------------------------------------------------------------- predictor

	task automatic push_point(input int px, input int py, input crbc_pkg::kind_t k);
		bez_pt_t p;
		p.x         = px[CW+1:0];
		p.y         = py[CW-1:0];
		p.kind      = k;
		p.run_end   = 1'b0;
		p.curve_end = 1'b0;
		bez_expect.push_back(p);
	endtask

	// one Catmull-Rom segment p1->p2: two controls then the end point.
	// Offsets are neighbour differences / 6 (int division truncates toward zero);
	// control y is clamped between the segment's end y values.
	task automatic push_segment(input int x0, input int y0, input int x1, input int y1,
			input int x2, input int y2, input int x3, input int y3);
		int lo;
		int hi;
		int c1y;
		int c2y;
		lo  = (y1 < y2) ? y1 : y2;
		hi  = (y1 < y2) ? y2 : y1;
		c1y = y1 + (y2 - y0) / 6;
		c2y = y2 - (y3 - y1) / 6;
		if (c1y < lo) c1y = lo;
		if (c1y > hi) c1y = hi;
		if (c2y < lo) c2y = lo;
		if (c2y > hi) c2y = hi;
		push_point(x1 + (x2 - x0) / 6, c1y, crbc_pkg::KIND_CTRL1);
		push_point(x2 - (x3 - x1) / 6, c2y, crbc_pkg::KIND_CTRL2);
		push_point(x2, y2, crbc_pkg::KIND_END);
	endtask

	// expected points for one accepted vertex; missing end neighbours repeat the end vertex
	task automatic bezier_predict(input logic [CW-1:0] vx, input logic [CW-1:0] vy,
			input logic last);
		int x;
		int y;
		int n0;
		x  = $signed(vx);
		y  = $signed(vy);
		n0 = bez_expect.size();
		case (pts_held)
			1: begin
				// two-point curve: both vertices as they are
				if (last) begin
					push_point(win_x[0], win_y[0], crbc_pkg::KIND_PLAIN);
					push_point(x, y, crbc_pkg::KIND_PLAIN);
				end
			end
			2: begin
				push_point(win_x[0], win_y[0], crbc_pkg::KIND_START);
				push_segment(win_x[0], win_y[0], win_x[0], win_y[0],
					win_x[1], win_y[1], x, y);
				if (last)
					push_segment(win_x[0], win_y[0], win_x[1], win_y[1], x, y, x, y);
			end
			3: begin
				push_segment(win_x[0], win_y[0], win_x[1], win_y[1],
					win_x[2], win_y[2], x, y);
				if (last)
					push_segment(win_x[1], win_y[1], win_x[2], win_y[2], x, y, x, y);
			end
			default: ; // first vertex (or one-point curve): nothing out
		endcase
		if (bez_expect.size() > n0) begin
			bez_expect[$].run_end   = 1'b1;
			bez_expect[$].curve_end = last;
		end
		if (last) begin
			pts_held = 0;
		end else if (pts_held < 3) begin
			win_x[pts_held] = x;
			win_y[pts_held] = y;
			pts_held++;
		end else begin
			win_x[0] = win_x[1];  win_y[0] = win_y[1];
			win_x[1] = win_x[2];  win_y[1] = win_y[2];
			win_x[2] = x;         win_y[2] = y;
		end
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic void add_vertex(input int x, input int y, input logic last);
		vertex_t v;
		v.x    = x[CW-1:0];
		v.y    = y[CW-1:0];
		v.last = last;
		vertex_queue.push_back(v);
	endfunction

	// mix of full-range, small, mid-range and extreme coordinates
	function automatic int rand_coord();
		int pick;
		pick = $urandom_range(3);
		case (pick)
			0: return $signed(16'($urandom));
			1: return $urandom_range(100) - 50;
			2: begin
				case ($urandom_range(3))
					0: return -32768;
					1: return 32767;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $urandom_range(4000) - 2000;
		endcase
	endfunction

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			// previous offer taken (or none up): present the next vertex or idle
			if (vertex_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PC)) begin
				vertex_t v;
				v = vertex_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= SD_W'({v.y, v.x});
				s_tlast  <= v.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure, plus one long hold-off so the job queue
	// fills and s_tready drops while the driver keeps offering
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (!hold_done && n_results >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CY;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= IDLE_PC);
		end
	end

	// ---------------------------------------------------------------- monitor

	// outputs are checked before the same edge's input transfer is predicted;
	// results always trail their vertex through the queue and pipeline registers, so order holds
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				bez_pt_t want;
				bez_pt_t got;
				got.x         = m_tdata[CW+1:0];
				got.y         = m_tdata[2*CW+1:CW+2];
				got.kind      = crbc_pkg::kind_t'(m_tuser[2:0]);
				got.curve_end = m_tuser[3];
				got.run_end   = m_tlast;
				n_results <= n_results + 1;
				if (bez_expect.size() == 0) begin
					$error("unexpected result: out_x %0d out_y %0d point_kind %0d",
						got.x, got.y, got.kind);
					err_count++;
				end else begin
					want = bez_expect.pop_front();
					if (got.x !== want.x) begin
						$error("out_x: expected %0d, got %0d", want.x, got.x);
						err_count++;
					end
					if (got.y !== want.y) begin
						$error("out_y: expected %0d, got %0d", want.y, got.y);
						err_count++;
					end
					if (got.kind !== want.kind) begin
						$error("point_kind: expected %0d, got %0d", want.kind, got.kind);
						err_count++;
					end
					if (got.run_end !== want.run_end) begin
						$error("last_in_run: expected %0b, got %0b", want.run_end, got.run_end);
						err_count++;
					end
					if (got.curve_end !== want.curve_end) begin
						$error("end_of_curve: expected %0b, got %0b",
							want.curve_end, got.curve_end);
						err_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				bezier_predict(s_tdata[CW-1:0], s_tdata[2*CW-1:CW], s_tlast);
				n_vertices <= n_vertices + 1;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int n_rand;
		int len;
		int r;
		pts_held = 0;

		// one-point curve: no output, state clears
		add_vertex(32767, -32768, 1'b1);
		// two-point curve: plain vertices, extremes
		add_vertex(-32768, 32767, 1'b0);
		add_vertex(32767, -32768, 1'b1);
		// three points: start, two segments from one vertex, widest x offsets
		add_vertex(-32768, -32768, 1'b0);
		add_vertex(32767, 32767, 1'b0);
		add_vertex(-32768, -32768, 1'b1);
		// four points: steady segment then final segment, y clamps at both ends
		add_vertex(0, 0, 1'b0);
		add_vertex(32767, -32768, 1'b0);
		add_vertex(-32768, 32767, 1'b0);
		add_vertex(32767, 32767, 1'b1);
		// zig-zag y: controls overshoot and get clamped
		add_vertex(100, 0, 1'b0);
		add_vertex(200, 600, 1'b0);
		add_vertex(300, 10, 1'b0);
		add_vertex(400, 900, 1'b0);
		add_vertex(500, -5, 1'b1);
		// small negatives: truncation toward zero on the divide
		add_vertex(1, 1, 1'b0);
		add_vertex(-1, -1, 1'b0);
		add_vertex(7, -7, 1'b0);
		add_vertex(-6, 6, 1'b0);
		add_vertex(13, -13, 1'b0);
		add_vertex(0, 0, 1'b1);

		// random curves, mostly three points or more
		n_rand = 0;
		while (n_rand < N_RAND) begin
			r   = $urandom_range(9);
			len = (r == 0) ? 1 : (r == 1) ? 2 : $urandom_range(10, 3);
			for (int i = 0; i < len; i++)
				add_vertex(rand_coord(), rand_coord(), i == len - 1);
			n_rand += len;
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (vertex_queue.size() != 0 || s_tvalid || bez_expect.size() != 0)
			@(posedge clk);
		// no stray results after the last expected one
		repeat (16) @(posedge clk);

		if (err_count == 0)
			$display("** catmull_rom_bezier_controls: PASSED **");
		else
			$display("** catmull_rom_bezier_controls: FAILED **");
		$finish;
	end

	initial begin
		#2000000;
		$display("** catmull_rom_bezier_controls: FAILED **");
		$finish;
	end

endmodule
